FILE: sv/distance_link_contact_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// Distance link contact generator - assertion macros
// Immediate-implication and next-cycle checks, sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_LINK_CONTACT_GENERATOR_UNIT_MACROS_SVH
`define DISTANCE_LINK_CONTACT_GENERATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLCG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("dlcg check failed");

// Consequent must hold in the cycle after the antecedent.
`define DLCG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("dlcg check failed");

`endif

FILE: sv/dlcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcg_pkg
// Widths, constants and stage records shared by the link contact generator.
// ----------------------------------------------------------------------------
package dlcg_pkg;

	localparam int CW  = 32;          // coordinate width
	localparam int FB  = 16;          // fraction bits
	localparam int IW  = 16;          // particle id width
	localparam int BW  = 17;          // restitution width
	localparam int DW  = CW + 1;      // coordinate difference / magnitude width
	localparam int SW  = 2 * DW;      // squared distance width
	localparam int RW  = DW;          // square root width
	localparam int QW  = FB + 1;      // normal quotient width
	localparam int NW  = FB + 2;      // signed normal width
	localparam int LAT = 3 + RW + 1 + QW + 1;

	localparam logic signed [NW-1:0] NORM_ONE = NW'(1) <<< FB;

	localparam logic OP_CABLE = 1'b0;
	localparam logic OP_ROD   = 1'b1;

	typedef struct packed {
		logic          op;
		logic          anch;
		logic [IW-1:0] id_a;
		logic [IW-1:0] id_b;
		logic [2:0]    sgn;
		logic [DW-1:0] mag_x;
		logic [DW-1:0] mag_y;
		logic [DW-1:0] mag_z;
		logic [CW-1:0] target;
		logic [BW-1:0] bounce;
	} side_t;

	typedef struct packed {
		logic          hit;
		logic          flip;
		logic          len_zero;
		logic          op;
		logic          anch;
		logic [IW-1:0] id_a;
		logic [IW-1:0] id_b;
		logic [2:0]    sgn;
		logic [CW-1:0] pen;
		logic [BW-1:0] bounce;
	} tail_t;

endpackage

FILE: sv/dlcg_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcg_req_if
// Link request channel: valid/ready handshake with endpoint payload.
// ----------------------------------------------------------------------------
interface dlcg_req_if
	import dlcg_pkg::*;
;
	logic          valid;
	logic          ready;
	logic          op;
	logic          anchored;
	logic [IW-1:0] id_a;
	logic [IW-1:0] id_b;
	logic signed [CW-1:0] pos_a_x;
	logic signed [CW-1:0] pos_a_y;
	logic signed [CW-1:0] pos_a_z;
	logic signed [CW-1:0] pos_b_x;
	logic signed [CW-1:0] pos_b_y;
	logic signed [CW-1:0] pos_b_z;
	logic [CW-1:0] target_length;
	logic [BW-1:0] bounce;

	modport source (output valid, op, anchored, id_a, id_b, pos_a_x, pos_a_y, pos_a_z,
		pos_b_x, pos_b_y, pos_b_z, target_length, bounce, input ready);
	modport sink (input valid, op, anchored, id_a, id_b, pos_a_x, pos_a_y, pos_a_z,
		pos_b_x, pos_b_y, pos_b_z, target_length, bounce, output ready);
endinterface

FILE: sv/dlcg_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcg_rsp_if
// Contact result channel: valid/ready handshake with contact payload.
// ----------------------------------------------------------------------------
interface dlcg_rsp_if
	import dlcg_pkg::*;
;
	logic          valid;
	logic          ready;
	logic          has_contact;
	logic [IW-1:0] out_id_a;
	logic [IW-1:0] out_id_b;
	logic          out_anchored;
	logic signed [NW-1:0] normal_x;
	logic signed [NW-1:0] normal_y;
	logic signed [NW-1:0] normal_z;
	logic [CW-1:0] penetration;
	logic [BW-1:0] out_bounce;

	modport source (output valid, has_contact, out_id_a, out_id_b, out_anchored,
		normal_x, normal_y, normal_z, penetration, out_bounce, input ready);
	modport sink (input valid, has_contact, out_id_a, out_id_b, out_anchored,
		normal_x, normal_y, normal_z, penetration, out_bounce, output ready);
endinterface

FILE: sv/dlcg_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcg_div_lane
// Pipelined restoring divider: q = (m << FB) / len, one quotient bit a stage.
// ----------------------------------------------------------------------------
module dlcg_div_lane
	import dlcg_pkg::*;
(
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] m,
	input  logic [DW-1:0] len,
	output logic [QW-1:0] q
);

	logic [DW:0]   rem_s [QW];
	logic [DW-1:0] len_s [QW];
	logic [QW-1:0] q_s   [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0]   rem_in;
		logic [DW-1:0] len_in;
		logic [QW-1:0] q_in;
		logic          take;
		logic [DW:0]   rem_new;

		if (k == 0) begin : g_first
			assign rem_in = {1'b0, m};
			assign len_in = len;
			assign q_in   = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign len_in = len_s[k-1];
			assign q_in   = q_s[k-1];
		end

		assign take    = rem_in >= {1'b0, len_in};
		assign rem_new = take ? rem_in - {1'b0, len_in} : rem_in;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= {rem_new[DW-1:0], 1'b0};
				len_s[k] <= len_in;
				q_s[k]   <= {q_in[QW-2:0], take};
			end
		end
	end

	assign q = q_s[QW-1];

endmodule

FILE: sv/distance_link_contact_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_link_contact_generator_unit
// Cable / rod link contact generator with pipelined root and normal divide.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one link request (kind, anchor flag, ids, endpoint positions,
//   target length, restitution); rsp returns exactly one result per request,
//   in order, with has_contact low and all other fields zero when the link
//   is slack.
//   Stages: difference, square, sum, 33 square root stages
//   (one root bit each), a compare stage, 17 divider stages (one normal bit
//   each, three lanes) and the output register.
//   Throughput is one request per cycle while the output is not stalled; every stage is a register.
//   The whole pipeline advances as one: req.ready is high whenever the output
//   register is empty or being taken, so when the receiver stalls a valid
//   result, every stage holds and req.ready drops until rsp.ready returns.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "distance_link_contact_generator_unit_macros.svh"

module distance_link_contact_generator_unit
	import dlcg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dlcg_req_if.sink   req,
	dlcg_rsp_if.source rsp
);

	logic           en;
	logic [LAT-1:0] vld_q;

	assign en        = !vld_q[LAT-1] || rsp.ready;
	assign req.ready = en;
	assign rsp.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], req.valid};
		end
	end

	// stage 1: differences B - A
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	side_t                side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {req.pos_b_x[CW-1], req.pos_b_x} - {req.pos_a_x[CW-1], req.pos_a_x};
			dy_s1 <= {req.pos_b_y[CW-1], req.pos_b_y} - {req.pos_a_y[CW-1], req.pos_a_y};
			dz_s1 <= {req.pos_b_z[CW-1], req.pos_b_z} - {req.pos_a_z[CW-1], req.pos_a_z};
			side_s1.op     <= req.op;
			side_s1.anch   <= req.anchored;
			side_s1.id_a   <= req.id_a;
			side_s1.id_b   <= req.id_b;
			side_s1.sgn    <= '0;
			side_s1.mag_x  <= '0;
			side_s1.mag_y  <= '0;
			side_s1.mag_z  <= '0;
			side_s1.target <= req.target_length;
			side_s1.bounce <= req.bounce;
		end
	end

	// stage 2: magnitudes and squares
	logic [DW-1:0] mx, my, mz;
	logic [SW-1:0] sqx_s2, sqy_s2, sqz_s2;
	side_t         side_m;
	side_t         side_s2;

	assign mx = dx_s1[DW-1] ? DW'(0) - dx_s1 : dx_s1;
	assign my = dy_s1[DW-1] ? DW'(0) - dy_s1 : dy_s1;
	assign mz = dz_s1[DW-1] ? DW'(0) - dz_s1 : dz_s1;

	always_comb begin
		side_m       = side_s1;
		side_m.sgn   = {dz_s1[DW-1], dy_s1[DW-1], dx_s1[DW-1]};
		side_m.mag_x = mx;
		side_m.mag_y = my;
		side_m.mag_z = mz;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= mx * mx;
			sqy_s2  <= my * my;
			sqz_s2  <= mz * mz;
			side_s2 <= side_m;
		end
	end

	// stage 3: squared distance
	logic [SW-1:0] sum_s3;
	side_t         side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sqx_s2 + sqy_s2 + sqz_s2;
			side_s3 <= side_s2;
		end
	end

	// square root: one root bit per stage
	logic [SW-1:0] rad_sq  [RW];
	logic [RW+1:0] rem_sq  [RW];
	logic [RW-1:0] root_sq [RW];
	side_t         side_sq [RW];

	for (genvar k = 0; k < RW; k++) begin : g_root
		logic [SW-1:0] rad_in;
		logic [RW+1:0] rem_in;
		logic [RW-1:0] root_in;
		side_t         side_in;
		logic [RW+3:0] sh;
		logic [RW+3:0] trial;
		logic [RW+3:0] dif;
		logic          ge;

		if (k == 0) begin : g_first
			assign rad_in  = sum_s3;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = side_s3;
		end else begin : g_next
			assign rad_in  = rad_sq[k-1];
			assign rem_in  = rem_sq[k-1];
			assign root_in = root_sq[k-1];
			assign side_in = side_sq[k-1];
		end

		assign sh    = {rem_in, rad_in[SW-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign dif   = sh - trial;
		assign ge    = sh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_sq[k]  <= {rad_in[SW-3:0], 2'b00};
				rem_sq[k]  <= ge ? dif[RW+1:0] : sh[RW+1:0];
				root_sq[k] <= {root_in[RW-2:0], ge};
				side_sq[k] <= side_in;
			end
		end
	end

	// compare stage: contact decision and penetration
	logic [DW-1:0] len, tgt, pdiff;
	logic          len_ge;
	logic [DW-1:0] len_ev;
	tail_t         tail_ev;
	side_t         side_ev;

	assign len    = root_sq[RW-1];
	assign tgt    = {1'b0, side_sq[RW-1].target};
	assign len_ge = len >= tgt;
	assign pdiff  = len_ge ? len - tgt : tgt - len;

	always_ff @(posedge clk) begin
		if (en) begin
			len_ev           <= len;
			side_ev          <= side_sq[RW-1];
			tail_ev.hit      <= (side_sq[RW-1].op == OP_ROD) ? (len != tgt) : len_ge;
			tail_ev.flip     <= (side_sq[RW-1].op == OP_ROD) && !len_ge;
			tail_ev.len_zero <= len == '0;
			tail_ev.op       <= side_sq[RW-1].op;
			tail_ev.anch     <= side_sq[RW-1].anch;
			tail_ev.id_a     <= side_sq[RW-1].id_a;
			tail_ev.id_b     <= side_sq[RW-1].id_b;
			tail_ev.sgn      <= side_sq[RW-1].sgn;
			tail_ev.pen      <= pdiff[DW-1] ? '1 : pdiff[CW-1:0];
			tail_ev.bounce   <= side_sq[RW-1].bounce;
		end
	end

	// normal divide lanes
	logic [QW-1:0] qx, qy, qz;

	dlcg_div_lane u_div_x (.clk(clk), .en(en), .m(side_ev.mag_x), .len(len_ev), .q(qx));
	dlcg_div_lane u_div_y (.clk(clk), .en(en), .m(side_ev.mag_y), .len(len_ev), .q(qy));
	dlcg_div_lane u_div_z (.clk(clk), .en(en), .m(side_ev.mag_z), .len(len_ev), .q(qz));

	tail_t tail_dv [QW];

	always_ff @(posedge clk) begin
		if (en) begin
			tail_dv[0] <= tail_ev;
			for (int i = 1; i < QW; i++) begin
				tail_dv[i] <= tail_dv[i-1];
			end
		end
	end

	// output stage: sign, gate and register the result
	tail_t           tl;
	logic            keep_n;
	logic [NW-1:0]   ex, ey, ez;

	assign tl     = tail_dv[QW-1];
	assign keep_n = tl.hit && !tl.len_zero;
	assign ex     = {1'b0, qx};
	assign ey     = {1'b0, qy};
	assign ez     = {1'b0, qz};

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.has_contact  <= tl.hit;
			rsp.out_id_a     <= tl.hit ? tl.id_a : '0;
			rsp.out_id_b     <= (tl.hit && !tl.anch) ? tl.id_b : '0;
			rsp.out_anchored <= tl.hit && tl.anch;
			rsp.normal_x     <= !keep_n ? '0 : ((tl.sgn[0] ^ tl.flip) ? NW'(0) - ex : ex);
			rsp.normal_y     <= !keep_n ? '0 : ((tl.sgn[1] ^ tl.flip) ? NW'(0) - ey : ey);
			rsp.normal_z     <= !keep_n ? '0 : ((tl.sgn[2] ^ tl.flip) ? NW'(0) - ez : ez);
			rsp.penetration  <= tl.hit ? tl.pen : '0;
			rsp.out_bounce   <= (tl.hit && tl.op == OP_CABLE) ? tl.bounce : '0;
		end
	end

	`DLCG_ASSERT_NOW(a_stall_blocks_req, rsp.valid && !rsp.ready, !req.ready)
	`DLCG_ASSERT_NEXT(a_stall_holds_pen, rsp.valid && !rsp.ready, $stable(rsp.penetration))
	`DLCG_ASSERT_NOW(a_slack_is_zero, rsp.valid && !rsp.has_contact, rsp.penetration == '0 && rsp.normal_x == '0 && rsp.out_bounce == '0)
	`DLCG_ASSERT_NOW(a_anchor_no_id_b, rsp.valid && rsp.out_anchored, rsp.out_id_b == '0)
	`DLCG_ASSERT_NOW(a_normal_unit, rsp.valid, rsp.normal_x <= NORM_ONE && rsp.normal_x >= -NORM_ONE)

endmodule

FILE: verif/dlcg_link_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlcg_link_checker
// Watches the link request and contact result channels, computes the expected
// contact for every accepted request and compares each result field by field.
// ----------------------------------------------------------------------------
module dlcg_link_checker
	import dlcg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	dlcg_req_if      req,
	dlcg_rsp_if      rsp,
	output int       fail_count,
	output int       pending
);

	typedef struct packed {
		logic                 has_contact;
		logic [IW-1:0]        id_a;
		logic [IW-1:0]        id_b;
		logic                 anch;
		logic signed [NW-1:0] nx;
		logic signed [NW-1:0] ny;
		logic signed [NW-1:0] nz;
		logic [CW-1:0]        pen;
		logic [BW-1:0]        bounce;
	} contact_t;

	contact_t contact_q[$];

	function automatic logic signed [NW-1:0] unit_comp(logic signed [DW-1:0] d,
			logic [DW-1:0] len, logic flip);
		logic [DW-1:0]  m;
		logic [63:0]    q;
		logic signed [63:0] s;
		if (len == 0)
			return '0;
		m = d[DW-1] ? DW'(-d) : DW'(d);
		q = ({31'b0, m} << FB) / {31'b0, len};
		s = ((d < 0) != flip) ? -$signed(q) : $signed(q);
		return s[NW-1:0];
	endfunction

	function automatic contact_t link_contact(logic op, logic anch,
			logic [IW-1:0] ia, logic [IW-1:0] ib,
			logic signed [CW-1:0] ax, logic signed [CW-1:0] ay, logic signed [CW-1:0] az,
			logic signed [CW-1:0] bx, logic signed [CW-1:0] by, logic signed [CW-1:0] bz,
			logic [CW-1:0] tgt, logic [BW-1:0] bnc);
		contact_t c;
		logic signed [DW-1:0] dx, dy, dz;
		logic [127:0] sq;
		logic [63:0] len, cand, pen;
		logic hit, flip;
		c = '0;
		dx = DW'(bx) - DW'(ax);
		dy = DW'(by) - DW'(ay);
		dz = DW'(bz) - DW'(az);
		sq = 128'($signed(dx) * $signed(dx)) + 128'($signed(dy) * $signed(dy))
			+ 128'($signed(dz) * $signed(dz));
		len = 0;
		for (int b = 63; b >= 0; b--) begin
			cand = len | (64'd1 << b);
			if ({64'b0, cand} * {64'b0, cand} <= sq)
				len = cand;
		end
		flip = 1'b0;
		if (op == OP_ROD) begin
			hit = len != {32'b0, tgt};
			flip = len < {32'b0, tgt};
		end else begin
			hit = len >= {32'b0, tgt};
		end
		if (!hit)
			return c;
		pen = (len >= tgt) ? len - tgt : tgt - len;
		c.has_contact = 1'b1;
		c.id_a = ia;
		c.id_b = anch ? '0 : ib;
		c.anch = anch;
		c.nx = unit_comp(dx, len[DW-1:0], flip);
		c.ny = unit_comp(dy, len[DW-1:0], flip);
		c.nz = unit_comp(dz, len[DW-1:0], flip);
		c.pen = (pen > 64'hFFFF_FFFF) ? '1 : pen[CW-1:0];
		c.bounce = (op == OP_ROD) ? '0 : bnc;
		return c;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	assign pending = contact_q.size();

	initial fail_count = 0;

	always @(posedge clk) begin
		contact_t e;
		if (arst_n) begin
			if (req.valid && req.ready)
				contact_q.push_back(link_contact(req.op, req.anchored, req.id_a, req.id_b,
					req.pos_a_x, req.pos_a_y, req.pos_a_z, req.pos_b_x, req.pos_b_y,
					req.pos_b_z, req.target_length, req.bounce));
			if (rsp.valid && rsp.ready) begin
				if (contact_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					e = contact_q.pop_front();
					check_field("has_contact", e.has_contact, rsp.has_contact);
					check_field("out_id_a", e.id_a, rsp.out_id_a);
					check_field("out_id_b", e.id_b, rsp.out_id_b);
					check_field("out_anchored", e.anch, rsp.out_anchored);
					check_field("normal_x", NW'(e.nx), NW'(rsp.normal_x));
					check_field("normal_y", NW'(e.ny), NW'(rsp.normal_y));
					check_field("normal_z", NW'(e.nz), NW'(rsp.normal_z));
					check_field("penetration", e.pen, rsp.penetration);
					check_field("out_bounce", e.bounce, rsp.out_bounce);
				end
			end
		end
	end

endmodule

FILE: verif/tb_distance_link_contact_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_link_contact_generator_unit
// Drives directed and random cable/rod link requests with random idle bursts
// and a long result stall; the checker predicts and compares every contact.
// ----------------------------------------------------------------------------
module tb_distance_link_contact_generator_unit;
	import dlcg_pkg::*;

	localparam int RANDOM_REQS = 1330;
	localparam int QUIET_REQS  = 200;
	localparam int MAX_CYCLES  = 400000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	bit   quiet;
	bit   hold_rsp;

	dlcg_req_if req ();
	dlcg_rsp_if rsp ();

	distance_link_contact_generator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	dlcg_link_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > MAX_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side: random stall bursts, one long hold, none near the end
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 19);
				rsp.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	function automatic logic [CW-1:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $signed(16'($urandom())) <<< $urandom_range(0, 16);
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			default: return $signed(12'($urandom())) <<< 8;
		endcase
	endfunction

	// drive one request and hold it until taken
	task automatic send_link(logic op, logic anch, logic [IW-1:0] ia, logic [IW-1:0] ib,
			logic [CW-1:0] ax, logic [CW-1:0] ay, logic [CW-1:0] az,
			logic [CW-1:0] bx, logic [CW-1:0] by, logic [CW-1:0] bz,
			logic [CW-1:0] tgt, logic [BW-1:0] bnc);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.anchored <= anch;
		req.id_a <= ia;
		req.id_b <= ib;
		req.pos_a_x <= ax;
		req.pos_a_y <= ay;
		req.pos_a_z <= az;
		req.pos_b_x <= bx;
		req.pos_b_y <= by;
		req.pos_b_z <= bz;
		req.target_length <= tgt;
		req.bounce <= bnc;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_random();
		logic [CW-1:0] ax, ay, az, bx, by, bz, tgt;
		logic [63:0] d;
		int mode;
		logic op;
		mode = $urandom_range(0, 9);
		ax = rand_coord(mode % 5);
		ay = rand_coord($urandom_range(0, 4));
		az = rand_coord(mode % 5);
		bx = rand_coord($urandom_range(0, 4));
		by = rand_coord(mode % 5);
		bz = rand_coord($urandom_range(0, 4));
		op = 1'($urandom());
		// aim the target near the x-axis distance so both sides of it are hit
		d = ($signed(64'($signed(bx))) - $signed(64'($signed(ax))));
		d = d[63] ? -d : d;
		case ($urandom_range(0, 3))
			0: tgt = $urandom();
			1: tgt = d[CW-1:0] + $urandom_range(0, 3) - 1;
			2: tgt = (ax == bx && ay == by && az == bz) ? '0 : d[CW-1:0];
			default: tgt = $urandom_range(0, 1) ? '1 : '0;
		endcase
		send_link(op, 1'($urandom()), IW'($urandom()), IW'($urandom()),
			ax, ay, az, bx, by, bz, tgt,
			$urandom_range(0, 1) ? BW'($urandom_range(0, 65536)) : BW'($urandom()));
	endtask

	initial begin
		cycle_count = 0;
		quiet = 1'b0;
		hold_rsp = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = OP_CABLE;
		req.anchored = 1'b0;
		req.id_a = '0;
		req.id_b = '0;
		req.pos_a_x = '0;
		req.pos_a_y = '0;
		req.pos_a_z = '0;
		req.pos_b_x = '0;
		req.pos_b_y = '0;
		req.pos_b_z = '0;
		req.target_length = '0;
		req.bounce = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero distance: cable hits at zero target, rod slack, rod compressed
		send_link(OP_CABLE, 0, 16'h0001, 16'h0002, 0, 0, 0, 0, 0, 0, 0, 17'h10000);
		send_link(OP_ROD, 0, 16'hFFFF, 16'hFFFF, 5, 5, 5, 5, 5, 5, 0, 17'h1FFFF);
		send_link(OP_ROD, 1, 16'h1234, 16'h5678, 0, 0, 0, 0, 0, 0, 32'h10000, 17'h1234);
		// axis-aligned unit links, cable slack vs taut, rod compressed; a 3-4-5 rod at length
		send_link(OP_CABLE, 0, 1, 2, 0, 0, 0, 32'h10000, 0, 0, 32'h20000, 17'h8000);
		send_link(OP_CABLE, 1, 3, 4, 0, 0, 0, 0, 32'h30000, 0, 32'h20000, 17'h8000);
		send_link(OP_ROD, 0, 5, 6, 0, 0, 0, 0, 0, 32'hFFFF_0000, 32'h20000, 17'h8000);
		send_link(OP_ROD, 1, 7, 8, 0, 0, 0, 0, 0, 32'h10000, 32'h20000, 17'h8000);
		send_link(OP_ROD, 0, 9, 10, 0, 0, 0, 32'h30000, 32'h40000, 0, 32'h50000, 0);
		// sub-resolution distance floors to the target
		send_link(OP_ROD, 0, 11, 12, 0, 0, 0, 1, 1, 0, 1, 0);
		send_link(OP_CABLE, 0, 11, 12, 0, 0, 0, 1, 1, 0, 1, 0);
		// extreme corners and targets; penetration saturates for the cable corner link
		send_link(OP_CABLE, 0, 0, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 17'h1FFFF);
		send_link(OP_ROD, 1, 16'hFFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 17'h1FFFF);
		send_link(OP_ROD, 0, 16'hAAAA, 16'h5555, 0, 0, 0, 1, 0, 0, 32'hFFFF_FFFF, 0);
		send_link(OP_CABLE, 0, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF, 0, 0, 0, 0, 0,
			32'hFFFF_FFFF, 17'h10000);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == 400)
				hold_rsp = 1'b1;
			if (i == RANDOM_REQS - QUIET_REQS)
				quiet = 1'b1;
			send_random();
		end
		req.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/dlcg_pkg.sv
sv/dlcg_req_if.sv
sv/dlcg_rsp_if.sv
sv/dlcg_div_lane.sv
sv/distance_link_contact_generator_unit.sv
verif/dlcg_link_checker.sv
verif/tb_distance_link_contact_generator_unit.sv
